FILE: hdl/vppt_pkg.sv
package vppt_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned POS_W = 16;
  localparam int unsigned TOL_W = 16;
  localparam int unsigned ENTRY_W = 2 * POS_W;

  // Reset value of the match radius in millimetres
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(50);

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_y_mm;
  } in_t;

  typedef struct packed {
    logic already_visited;
    logic was_stored;
    logic table_full;
  } out_t;

endpackage

FILE: hdl/vppt_ram.sv
module vppt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/visited_position_proximity_table.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  vppt_pkg::in_t  (pos_x_mm, pos_y_mm)
// out       output     out_valid_o/out_stall_i vppt_pkg::out_t (visited, stored, full)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i      (tolerance_mm)
//
// After acceptance a request makes one read per stored entry from the position
// memory; each read entry then passes the registered read and the difference,
// square and compare stages of the scan before the result is registered. Reset
// empties the table and sets tolerance_mm to 50.
// The next request is accepted while a finished result still waits on
// out_stall_i; a result that finds the output register full holds until it drains.
module visited_position_proximity_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vppt_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vppt_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [15:0]     cfg_data_i
);

  import vppt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [TOL_W-1:0]       tol_q;
  logic [2*TOL_W-1:0]     tol2_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       rd_cnt_q, rd_cnt_d;
  in_t                    item_q;
  logic                   v1_q, v2_q, v3_q;
  logic [POS_W-1:0]       dx_q, dy_q;
  logic [2*POS_W-1:0]     sqx_q, sqy_q;
  logic                   visited_q, dup_q;
  logic                   out_valid_q;
  out_t                   out_q;

  logic                   in_accept;
  logic                   rd_issue;
  logic                   out_free;
  logic                   finish;
  logic                   do_store;
  logic [ENTRY_W-1:0]     rdata;
  logic signed [POS_W:0]  diff_x, diff_y;
  logic [POS_W:0]         mag_x, mag_y;
  logic [2*POS_W:0]       dist2;
  out_t                   result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_issue    = (state_q == ST_SCAN) && (rd_cnt_q < count_q);
  assign finish      = (state_q == ST_DONE) && out_free;

  // Decide the outcome of the finished scan
  always_comb begin
    result   = '0;
    do_store = 1'b0;
    if (visited_q) begin
      result.already_visited = 1'b1;
    end else if (dup_q) begin
      result = '0;
    end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
      result.table_full = 1'b1;
    end else begin
      result.was_stored = 1'b1;
      do_store          = 1'b1;
    end
  end

  vppt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (finish && do_store),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({item_q.pos_x_mm, item_q.pos_y_mm}),
    .re_i    (rd_issue),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Sequence the scan
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    count_d  = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d  = ST_SCAN;
          rd_cnt_d = '0;
        end
      end
      ST_SCAN: begin
        if (rd_issue) begin
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (do_store) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      count_q  <= '0;
      tol_q    <= TOL_RESET;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      count_q  <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  // Capture the request and square the radius
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
      tol2_q <= tol_q * tol_q;
    end
  end

  // Absolute differences of the entry just read
  assign diff_x = $signed({rdata[ENTRY_W-1], rdata[ENTRY_W-1:POS_W]})
                  - $signed({item_q.pos_x_mm[POS_W-1], item_q.pos_x_mm});
  assign diff_y = $signed({rdata[POS_W-1], rdata[POS_W-1:0]})
                  - $signed({item_q.pos_y_mm[POS_W-1], item_q.pos_y_mm});
  assign mag_x  = diff_x[POS_W] ? (POS_W+1)'(-diff_x) : diff_x;
  assign mag_y  = diff_y[POS_W] ? (POS_W+1)'(-diff_y) : diff_y;
  assign dist2  = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= rd_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Difference and square stages
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      dx_q <= mag_x[POS_W-1:0];
      dy_q <= mag_y[POS_W-1:0];
    end
    if (v2_q) begin
      sqx_q <= dx_q * dx_q;
      sqy_q <= dy_q * dy_q;
    end
  end

  // Accumulate the match flags, cleared at each new request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= 1'b0;
      dup_q     <= 1'b0;
    end else if (in_accept) begin
      visited_q <= 1'b0;
      dup_q     <= 1'b0;
    end else if (v3_q) begin
      if (dist2 < {1'b0, tol2_q}) begin
        visited_q <= 1'b1;
      end
      if (dist2 == '0) begin
        dup_q <= 1'b1;
      end
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: test/visited_position_proximity_table_tb.sv
`timescale 1ns / 100ps

module visited_position_proximity_table_tb;
  import vppt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 8000;

  // Track the table contents and the results still owed by the block
  class proximity_scoreboard;
    logic signed [POS_W-1:0] seen_x [TABLE_DEPTH];
    logic signed [POS_W-1:0] seen_y [TABLE_DEPTH];
    int unsigned seen_count;
    logic [TOL_W-1:0] radius;
    out_t awaited [$];
    int unsigned failures;
    int unsigned requests;
    int unsigned hits;
    int unsigned stores;
    int unsigned drops;
    int unsigned repeats;

    function new();
      seen_count = 0;
      radius = TOL_RESET;
      failures = 0;
      requests = 0;
      hits = 0;
      stores = 0;
      drops = 0;
      repeats = 0;
    endfunction

    function void set_radius(logic [TOL_W-1:0] r);
      radius = r;
    endfunction

    // Scan the known positions and queue the result this request must give
    function void note_request(in_t req);
      longint dx;
      longint dy;
      longint dist2;
      longint radius2;
      bit hit;
      bit exact;
      out_t res;
      hit = 1'b0;
      exact = 1'b0;
      res = '0;
      radius2 = longint'(radius) * longint'(radius);
      for (int i = 0; i < seen_count; i++) begin
        dx = longint'($signed(req.pos_x_mm)) - longint'($signed(seen_x[i]));
        dy = longint'($signed(req.pos_y_mm)) - longint'($signed(seen_y[i]));
        dist2 = dx * dx + dy * dy;
        if (dist2 < radius2) begin
          hit = 1'b1;
          break;
        end
        if (dist2 == 0) exact = 1'b1;
      end
      requests++;
      if (hit) begin
        res.already_visited = 1'b1;
        hits++;
      end else if (exact) begin
        // already present: keep set semantics, store nothing
        repeats++;
      end else if (seen_count >= TABLE_DEPTH) begin
        res.table_full = 1'b1;
        drops++;
      end else begin
        seen_x[seen_count] = req.pos_x_mm;
        seen_y[seen_count] = req.pos_y_mm;
        seen_count++;
        res.was_stored = 1'b1;
        stores++;
      end
      awaited.push_back(res);
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        $error("result with no request pending: %b", got);
        failures++;
      end else begin
        want = awaited.pop_front();
        if (got.already_visited !== want.already_visited) begin
          $error("already_visited: expected %0b, got %0b",
                 want.already_visited, got.already_visited);
          failures++;
        end
        if (got.was_stored !== want.was_stored) begin
          $error("was_stored: expected %0b, got %0b", want.was_stored, got.was_stored);
          failures++;
        end
        if (got.table_full !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  proximity_scoreboard sb = new();
  bit idling_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  visited_position_proximity_table uut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #10 clk = ~clk;

  // Observe every handshake and feed the scoreboard
  always @(posedge clk) begin
    if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (cfg_valid_i && cfg_ready_o) sb.set_radius(cfg_data_i);
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("visited_position_proximity_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one position request and hold it until taken
  task automatic send_position(int x, int y);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i.pos_x_mm <= POS_W'(x);
    in_data_i.pos_y_mm <= POS_W'(y);
    do @(posedge clk); while (in_stall_o);
  endtask

  // Drop valid and wait for every owed result to drain
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tolerance(int unsigned tol);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= TOL_W'(tol);
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // Aim near a known position, repeat one exactly, or go anywhere
  task automatic send_mixed(int spread);
    int unsigned idx;
    int pick;
    idx = $urandom_range(0, sb.seen_count - 1);
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      send_position(int'($signed(sb.seen_x[idx])) + int'($urandom_range(0, 2 * spread)) - spread,
                    int'($signed(sb.seen_y[idx])) + int'($urandom_range(0, 2 * spread)) - spread);
    end else if (pick < 14) begin
      send_position($signed(sb.seen_x[idx]), $signed(sb.seen_y[idx]));
    end else begin
      send_position(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int unsigned tol;
    int spread;

    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset radius, boundary distance, corner coordinates
    send_position(0, 0);
    send_position(0, 49);
    send_position(0, 50);
    send_position(32767, 32767);
    send_position(-32768, -32768);
    send_position(-32768, 32767);
    send_position(32767, -32768);
    send_position(-1, -1);
    drain();

    // Zero radius: exact repeats are new but not stored again
    write_tolerance(0);
    send_position(0, 0);
    send_position(32767, 32767);
    send_position(1, 0);
    drain();

    write_tolerance(65535);
    send_position(100, -100);
    send_position(-32768, -32768);
    drain();

    write_tolerance(1);
    send_position(2, 0);
    send_position(1, 0);
    send_position(-21846, 21845);
    send_position(21845, -21846);
    drain();

    // Random blocks, each under its own radius
    for (int blk = 0; blk < 8; blk++) begin
      case ($urandom_range(0, 5))
        0: tol = 50;
        1: tol = 0;
        2: tol = 65535;
        3: tol = 1;
        4: tol = $urandom_range(0, 65535);
        default: tol = $urandom_range(2, 2000);
      endcase
      write_tolerance(tol);
      spread = (tol > 3000) ? 3000 : int'(tol) + 2;
      idling_on = (blk % 3 != 2);
      repeat (66) send_mixed(spread);
      drain();
    end

    // Last stretch without idling: near hits and exact repeats
    idling_on = 1'b0;
    write_tolerance(50);
    repeat (20) send_mixed(30);
    drain();
    write_tolerance(0);
    repeat (10) send_mixed(30);
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d position requests: %0d visited, %0d stored, %0d dropped as full,",
             sb.requests, sb.hits, sb.stores, sb.drops);
    $display("%0d exact repeats at zero radius; table ended with %0d entries.",
             sb.repeats, sb.seen_count);
    if (sb.failures == 0) begin
      $display("visited_position_proximity_table regression: pass");
    end else begin
      $display("visited_position_proximity_table regression: fail");
    end
    $finish;
  end

endmodule
